// ----- sv/pehr_pkg.sv -----
// Shared types, codes and constants for the pointer event to HID report block.
package pehr_pkg;

  localparam int XY_W        = 13;
  localparam int BTN_W       = 3;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RECT_W      = 13;
  localparam int AGE_W       = 16;
  localparam int LIMIT_W     = 8;
  localparam int SCALE_BITS  = 12;
  localparam int DELTA_MAX   = 127;
  localparam int DIV_STEPS   = 12;
  localparam int DIV_CNT_W   = 4;

  localparam logic [AGE_W-1:0]   LONG_PRESS_RESET = 16'd500;
  localparam logic [LIMIT_W-1:0] MOVE_LIMIT_RESET = 8'd5;

  localparam logic [BTN_W-1:0] BTN_NONE  = 3'b000;
  localparam logic [BTN_W-1:0] BTN_LEFT  = 3'b001;
  localparam logic [BTN_W-1:0] BTN_RIGHT = 3'b010;

  // request command codes (in_tuser)
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PRESS   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_MOVE    = 2'd3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ABS = 2'd1;
  localparam logic [1:0] MODE_REL = 2'd2;

  // report kinds (out_tuser)
  localparam logic [1:0] KIND_ABS    = 2'd0;
  localparam logic [1:0] KIND_REL    = 2'd1;
  localparam logic [1:0] KIND_RCLICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT  = 3'd6;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_ABS,
    ACT_ONE,
    ACT_CLICK
  } act_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_OUT,
    S_OUT2
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_step;
    logic load_out;
    logic second;
  } ctl_cmd_t;

  typedef struct packed {
    act_t action;
    logic div_last;
    logic pair;
  } ctl_stat_t;

endpackage

// ----- sv/pehr_ctrl.sv -----
// Control state machine: request sequencing, divider pacing and output register handshake.
module pehr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  pehr_pkg::ctl_stat_t stat,
  output pehr_pkg::ctl_cmd_t  ctl
);

  pehr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == pehr_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pehr_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = pehr_pkg::S_EXEC;
      end
      pehr_pkg::S_EXEC: begin
        case (stat.action)
          pehr_pkg::ACT_ABS:   state_nxt = pehr_pkg::S_DIV;
          pehr_pkg::ACT_ONE:   state_nxt = pehr_pkg::S_OUT;
          pehr_pkg::ACT_CLICK: state_nxt = pehr_pkg::S_OUT;
          default:             state_nxt = pehr_pkg::S_IDLE;
        endcase
      end
      pehr_pkg::S_DIV: begin
        if (stat.div_last) state_nxt = pehr_pkg::S_OUT;
      end
      pehr_pkg::S_OUT: begin
        if (out_free) state_nxt = stat.pair ? pehr_pkg::S_OUT2 : pehr_pkg::S_IDLE;
      end
      pehr_pkg::S_OUT2: begin
        if (out_free) state_nxt = pehr_pkg::S_IDLE;
      end
      default: state_nxt = pehr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      pehr_pkg::S_IDLE: ctl.capture  = in_tvalid;
      pehr_pkg::S_EXEC: ctl.exec     = 1'b1;
      pehr_pkg::S_DIV:  ctl.div_step = 1'b1;
      pehr_pkg::S_OUT:  ctl.load_out = out_free;
      pehr_pkg::S_OUT2: begin
        ctl.load_out = out_free;
        ctl.second   = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    if (ctl.load_out) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pehr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/pehr_dp.sv -----
// Datapath: config registers, touch state, report build, two-lane scaling divider, output register.
module pehr_dp #(
  parameter int POS_BITS = 16,
  localparam int IN_W = ((2 * POS_BITS + 4 + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [IN_W-1:0]                     in_tdata,
  input  logic [1:0]                          in_tuser,
  input  logic                                cfg_we,
  input  logic [pehr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pehr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  pehr_pkg::ctl_cmd_t                  ctl,
  output pehr_pkg::ctl_stat_t                 stat,
  output logic [pehr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [1:0]                          out_tuser,
  output logic                                out_tlast
);

  localparam int P      = POS_BITS;
  localparam int RW     = pehr_pkg::RECT_W;
  localparam int SB     = pehr_pkg::SCALE_BITS;
  localparam int XW     = pehr_pkg::XY_W;
  localparam int BW     = pehr_pkg::BTN_W;
  localparam int DW     = ((P > RW) ? P : RW) + 2;
  localparam int DLT_W  = P + 1;
  localparam int SUM_W  = P + 2;
  localparam int PAD_W  = pehr_pkg::OUT_TDATA_W - 2 * XW - BW;
  localparam logic signed [DLT_W-1:0] DMAX = DLT_W'(pehr_pkg::DELTA_MAX);
  localparam logic signed [DLT_W-1:0] DMIN = -DLT_W'(pehr_pkg::DELTA_MAX);

  // latched request
  logic [1:0]          cmd_r;
  logic signed [P-1:0] px_r, py_r;
  logic                left_r;
  logic [BW-1:0]       held_r;

  // configuration
  logic [1:0]                      mode_r;
  logic [RW-1:0]                   rect_left_r, rect_top_r, rect_width_r, rect_height_r;
  logic [pehr_pkg::AGE_W-1:0]      long_press_r;
  logic [pehr_pkg::LIMIT_W-1:0]    move_limit_r;

  // touch tracking
  logic                       touch_down_r, lp_done_r, moved_far_r, prev_valid_r;
  logic [pehr_pkg::AGE_W-1:0] press_age_r, age_inc;
  logic signed [P-1:0]        press_x_r, press_y_r, prev_x_r, prev_y_r;

  // pending report
  logic [1:0]    res_kind_r, res_kind_nxt;
  logic [XW-1:0] res_x_r, res_x_nxt, res_y_r, res_y_nxt;
  logic [BW-1:0] res_btn_r, res_btn_nxt;
  logic          res_last_r, res_last_nxt;

  // divider lanes: 0 = x, 1 = y
  logic [RW-1:0]                 rem_r [2];
  logic [SB-1:0]                 q_r [2];
  logic [RW-1:0]                 rem_nxt [2];
  logic [SB-1:0]                 q_nxt [2];
  logic [RW-1:0]                 div_w [2];
  logic [RW-1:0]                 rx [2];
  logic [RW+SB-1:0]              scaled [2];
  logic [RW:0]                   div_t [2];
  logic [RW:0]                   div_d [2];
  logic                          div_ge [2];
  logic [pehr_pkg::DIV_CNT_W-1:0] cnt_r;

  // output register
  logic [1:0]    o_kind_r;
  logic [XW-1:0] o_x_r, o_y_r;
  logic [BW-1:0] o_btn_r;
  logic          o_last_r;

  logic signed [DW-1:0]    off_x, off_y;
  logic signed [DLT_W-1:0] dx_raw, dy_raw, mx, my;
  logic [DLT_W-1:0]        ax, ay;
  logic [SUM_W-1:0]        travel;
  logic                    far;
  logic                    lp_fire;
  pehr_pkg::act_t          action;

  function automatic logic [RW-1:0] clamp_rect(input logic signed [DW-1:0] v,
                                               input logic [RW-1:0] lim);
    logic signed [DW-1:0] lim_s;
    lim_s = $signed(DW'(lim));
    if (v < 0) return '0;
    else if (v > lim_s) return lim;
    else return v[RW-1:0];
  endfunction

  function automatic logic [XW-1:0] clamp_delta(input logic signed [DLT_W-1:0] v);
    if (v > DMAX) return XW'(DMAX);
    else if (v < DMIN) return XW'(DMIN);
    else return XW'(v);
  endfunction

  // absolute mapping
  assign off_x = DW'(px_r) - $signed(DW'(rect_left_r));
  assign off_y = DW'(py_r) - $signed(DW'(rect_top_r));
  assign rx[0] = clamp_rect(off_x, rect_width_r);
  assign rx[1] = clamp_rect(off_y, rect_height_r);
  assign div_w[0] = rect_width_r;
  assign div_w[1] = rect_height_r;

  // relative delta and travel since press
  assign dx_raw = prev_valid_r ? (DLT_W'(px_r) - DLT_W'(prev_x_r)) : '0;
  assign dy_raw = prev_valid_r ? (DLT_W'(py_r) - DLT_W'(prev_y_r)) : '0;
  assign mx     = DLT_W'(px_r) - DLT_W'(press_x_r);
  assign my     = DLT_W'(py_r) - DLT_W'(press_y_r);
  assign ax     = mx[DLT_W-1] ? DLT_W'(-mx) : DLT_W'(mx);
  assign ay     = my[DLT_W-1] ? DLT_W'(-my) : DLT_W'(my);
  assign travel = SUM_W'(ax) + SUM_W'(ay);
  assign far    = travel > SUM_W'(move_limit_r);

  assign age_inc = (press_age_r != '1) ? press_age_r + 1'b1 : press_age_r;
  assign lp_fire = (mode_r == pehr_pkg::MODE_REL) && touch_down_r && !lp_done_r &&
                   !moved_far_r && (age_inc > long_press_r);

  always_comb begin
    action = pehr_pkg::ACT_NONE;
    if (cmd_r == pehr_pkg::CMD_TICK) begin
      if (lp_fire) action = pehr_pkg::ACT_ONE;
    end else if (mode_r == pehr_pkg::MODE_ABS) begin
      if (rect_width_r != '0 && rect_height_r != '0) action = pehr_pkg::ACT_ABS;
    end else if (mode_r == pehr_pkg::MODE_REL) begin
      case (cmd_r)
        pehr_pkg::CMD_MOVE:    action = pehr_pkg::ACT_ONE;
        pehr_pkg::CMD_RELEASE: begin
          if (left_r && !lp_done_r && !moved_far_r) action = pehr_pkg::ACT_CLICK;
        end
        default: action = pehr_pkg::ACT_NONE;
      endcase
    end
  end

  always_comb begin
    res_kind_nxt = pehr_pkg::KIND_REL;
    res_x_nxt    = '0;
    res_y_nxt    = '0;
    res_btn_nxt  = pehr_pkg::BTN_NONE;
    res_last_nxt = 1'b1;
    case (action)
      pehr_pkg::ACT_ABS: begin
        res_kind_nxt = pehr_pkg::KIND_ABS;
        res_btn_nxt  = held_r;
      end
      pehr_pkg::ACT_ONE: begin
        if (cmd_r == pehr_pkg::CMD_TICK) begin
          res_kind_nxt = pehr_pkg::KIND_RCLICK;
          res_btn_nxt  = pehr_pkg::BTN_RIGHT;
        end else begin
          res_x_nxt = clamp_delta(dx_raw);
          res_y_nxt = clamp_delta(dy_raw);
        end
      end
      pehr_pkg::ACT_CLICK: begin
        res_btn_nxt  = pehr_pkg::BTN_LEFT;
        res_last_nxt = 1'b0;
      end
      default: res_last_nxt = 1'b1;
    endcase
  end

  // restoring divide of rx*4095 by the rectangle size, one quotient bit per lane per cycle
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      scaled[i] = {rx[i], SB'(0)} - (RW + SB)'(rx[i]);
      div_t[i]  = {rem_r[i], q_r[i][SB-1]};
      div_ge[i] = div_t[i] >= {1'b0, div_w[i]};
      div_d[i]  = div_t[i] - {1'b0, div_w[i]};
      if (ctl.exec) begin
        rem_nxt[i] = scaled[i][RW+SB-1:SB];
        q_nxt[i]   = scaled[i][SB-1:0];
      end else begin
        rem_nxt[i] = div_ge[i] ? div_d[i][RW-1:0] : div_t[i][RW-1:0];
        q_nxt[i]   = {q_r[i][SB-2:0], div_ge[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec || ctl.div_step) begin
      for (int i = 0; i < 2; i++) begin
        rem_r[i] <= rem_nxt[i];
        q_r[i]   <= q_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (ctl.exec) cnt_r <= '0;
    else if (ctl.div_step) cnt_r <= cnt_r + 1'b1;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r  <= in_tuser;
      px_r   <= in_tdata[P-1:0];
      py_r   <= in_tdata[2*P-1:P];
      left_r <= in_tdata[2*P];
      held_r <= in_tdata[2*P+BW:2*P+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= pehr_pkg::MODE_OFF;
      rect_left_r   <= '0;
      rect_top_r    <= '0;
      rect_width_r  <= '0;
      rect_height_r <= '0;
      long_press_r  <= pehr_pkg::LONG_PRESS_RESET;
      move_limit_r  <= pehr_pkg::MOVE_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pehr_pkg::REG_MODE:        mode_r        <= cfg_wdata[1:0];
        pehr_pkg::REG_RECT_LEFT:   rect_left_r   <= cfg_wdata[RW-1:0];
        pehr_pkg::REG_RECT_TOP:    rect_top_r    <= cfg_wdata[RW-1:0];
        pehr_pkg::REG_RECT_WIDTH:  rect_width_r  <= cfg_wdata[RW-1:0];
        pehr_pkg::REG_RECT_HEIGHT: rect_height_r <= cfg_wdata[RW-1:0];
        pehr_pkg::REG_LONG_PRESS:  long_press_r  <= cfg_wdata[pehr_pkg::AGE_W-1:0];
        pehr_pkg::REG_MOVE_LIMIT:  move_limit_r  <= cfg_wdata[pehr_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // touch state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_down_r <= 1'b0;
      lp_done_r    <= 1'b0;
      moved_far_r  <= 1'b0;
      prev_valid_r <= 1'b0;
      press_age_r  <= '0;
      press_x_r    <= '0;
      press_y_r    <= '0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
    end else if (ctl.exec) begin
      if (cmd_r == pehr_pkg::CMD_TICK) begin
        press_age_r <= age_inc;
        // moved touch: long press is consumed silently
        if (mode_r == pehr_pkg::MODE_REL && touch_down_r && !lp_done_r &&
            (moved_far_r || age_inc > long_press_r))
          lp_done_r <= 1'b1;
      end else if (mode_r == pehr_pkg::MODE_REL) begin
        case (cmd_r)
          pehr_pkg::CMD_PRESS: begin
            if (left_r) begin
              touch_down_r <= 1'b1;
              press_age_r  <= '0;
              press_x_r    <= px_r;
              press_y_r    <= py_r;
              lp_done_r    <= 1'b0;
              moved_far_r  <= 1'b0;
            end
          end
          pehr_pkg::CMD_MOVE: begin
            prev_x_r     <= px_r;
            prev_y_r     <= py_r;
            prev_valid_r <= 1'b1;
            if (far) moved_far_r <= 1'b1;
          end
          pehr_pkg::CMD_RELEASE: begin
            if (left_r) touch_down_r <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      res_kind_r <= res_kind_nxt;
      res_x_r    <= res_x_nxt;
      res_y_r    <= res_y_nxt;
      res_btn_r  <= res_btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_last_r <= 1'b1;
    else if (ctl.exec) res_last_r <= res_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      o_kind_r <= res_kind_r;
      o_x_r    <= (res_kind_r == pehr_pkg::KIND_ABS) ? XW'(q_r[0]) : res_x_r;
      o_y_r    <= (res_kind_r == pehr_pkg::KIND_ABS) ? XW'(q_r[1]) : res_y_r;
      // second half of a click: release report
      o_btn_r  <= ctl.second ? pehr_pkg::BTN_NONE : res_btn_r;
      o_last_r <= ctl.second ? 1'b1 : res_last_r;
    end
  end

  assign stat.action   = action;
  assign stat.div_last = (cnt_r == pehr_pkg::DIV_CNT_W'(pehr_pkg::DIV_STEPS - 1));
  assign stat.pair     = !res_last_r;

  assign out_tdata = {PAD_W'(0), o_btn_r, o_y_r, o_x_r};
  assign out_tuser = o_kind_r;
  assign out_tlast = o_last_r;

endmodule

// ----- sv/pointer_event_to_hid_report.sv -----
// Top level: pointer events and ticks in, mouse reports out.
//
// Input stream: one request per pointer event or one-millisecond tick. in_tuser carries
// the command, in_tdata the position, the left-button flag and the held buttons.
// Output stream: mouse reports; out_tuser is the report kind and out_tlast marks the
// final report caused by a request (a left click gives two reports).
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle; write only
// while the block is idle.
// Timing: one request is worked at a time. An accepted request is captured, worked in
// an exec state and loaded from an output state into the output register; absolute
// reports first pass through the 12-step shift-subtract divider (one quotient bit per
// cycle, x and y side by side). A click loads its second report from a further output
// state, and a request that gives no report returns straight to idle. A new request is
// taken only once the block is back in idle.
// in_tready returns as soon as the last report sits in the output register, so the
// next request is taken while that report waits.
// Stall: a held report stays in the output register unchanged; the next report waits.
// Reset (rst_n low, synchronous): registers go to their defaults (mode disabled,
// long press 500 ticks, move limit 5), touch state clears and the output empties.
module pointer_event_to_hid_report #(
  parameter int POS_BITS = 16,
  localparam int IN_W = ((2 * POS_BITS + 4 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pos_x, pos_y, is_left, held_buttons, zero pad
  input  logic [IN_W-1:0]                  in_tdata,
  // cmd
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_x, out_y, buttons, zero pad
  output logic [pehr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // kind
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [pehr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pehr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pehr_pkg::ctl_cmd_t  ctl;
  pehr_pkg::ctl_stat_t stat;

  pehr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .ctl        (ctl)
  );

  pehr_dp #(.POS_BITS(POS_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- sv/pehr_chk.sv -----
// Port-level checker for the pointer event to HID report block, with its bind.
module pehr_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pehr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);

  localparam int XW = pehr_pkg::XY_W;
  localparam int BW = pehr_pkg::BTN_W;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled report changed");

  // one request in flight: input closes right after an accept
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");

  a_rclick_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pehr_pkg::KIND_RCLICK |->
      out_tlast && out_tdata[2*XW+BW-1:2*XW] == pehr_pkg::BTN_RIGHT &&
      out_tdata[2*XW-1:0] == '0)
    else $error("malformed right click");

  a_abs_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == pehr_pkg::KIND_ABS |->
      out_tlast && !out_tdata[XW-1] && !out_tdata[2*XW-1])
    else $error("absolute report out of range");

endmodule

bind pointer_event_to_hid_report pehr_chk u_pehr_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
